### hdl/lzpd_pkg.sv
// Shared types and constants for the LZ page decompressor.
`default_nettype none

package lzpd_pkg;

  localparam int BYTE_W    = 8;
  localparam int CNT_W     = 13;
  localparam int LIT_W     = 7;
  localparam int LEN_W     = 5;
  localparam int DIST_W    = 12;
  localparam int MATCH_BIT = 7;
  localparam int LEN_BIAS  = 4;

  localparam logic [CNT_W-1:0] OUT_LIMIT_RESET = 13'd4096;

  // register index as seen on paddr[2]
  localparam logic REG_OUT_LIMIT = 1'b0;

  // controller -> datapath
  typedef struct packed {
    logic accept;      // input beat taken this cycle
    logic lit_emit;    // literal byte to output and history
    logic match_start; // latch length and distance of a match
    logic rd;          // history read for the next match byte
    logic mwr;         // match byte to output and history
    logic status_now;  // final status with this beat
    logic status;      // deferred final status
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic slot_free;   // output register can take a result
    logic is_lit;      // current beat is a literal
    logic is_match;    // current beat completes a valid match token
    logic in_last;     // current beat ends the stream
    logic match_end;   // one match byte left
    logic held_last;   // the match in progress ends the stream
  } dp_stat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              byte_valid;
    logic              run_last;
    logic              done_res;
    logic              error;
    logic [CNT_W-1:0]  out_count;
  } out_item_t;

endpackage

`default_nettype wire

### hdl/lzpd_if.sv
// Valid/ready channel interfaces for compressed input and restored output.
`default_nettype none

interface lzpd_in_if;
  logic                      valid;
  logic                      ready;
  logic [lzpd_pkg::BYTE_W-1:0] in_byte;
  logic                      last_in;

  modport source (output valid, output in_byte, output last_in, input ready);
  modport sink   (input valid, input in_byte, input last_in, output ready);
endinterface

interface lzpd_out_if;
  logic                       valid;
  logic                       ready;
  logic [lzpd_pkg::BYTE_W-1:0] out_byte;
  logic                       byte_valid;
  logic                       run_last;
  logic                       done_res;
  logic                       error;
  logic [lzpd_pkg::CNT_W-1:0]  out_count;

  modport source (output valid, output out_byte, output byte_valid, output run_last,
                  output done_res, output error, output out_count, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input run_last,
                  input done_res, input error, input out_count, output ready);
endinterface

`default_nettype wire

### hdl/lzpd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lzpd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### hdl/lzpd_dp.sv
// Datapath: token parsing, page history, byte counter and output register.
`default_nettype none

module lzpd_dp #(
  parameter int PAGE_SIZE = 4096
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic [lzpd_pkg::CNT_W-1:0]    out_limit,
  input  wire logic [lzpd_pkg::BYTE_W-1:0]   in_byte,
  input  wire logic                          last_in,
  input  wire logic                          out_ready,
  input  wire lzpd_pkg::dp_cmd_t             cmd,
  output      lzpd_pkg::dp_stat_t            stat,
  output      logic                          out_valid,
  output      lzpd_pkg::out_item_t           out_item
);

  localparam int AW       = $clog2(PAGE_SIZE);
  localparam int CNT_MAX  = (1 << lzpd_pkg::CNT_W) - 1;
  localparam int PAGE_CAP = (PAGE_SIZE < CNT_MAX) ? PAGE_SIZE : CNT_MAX;

  typedef enum logic [1:0] {
    MODE_TOKEN,
    MODE_LIT,
    MODE_DIST,
    MODE_ERR
  } mode_t;

  mode_t                         mode, mode_next;
  logic [lzpd_pkg::LIT_W-1:0]    lits;
  logic [lzpd_pkg::BYTE_W-1:0]   held;
  logic [lzpd_pkg::CNT_W-1:0]    count;
  logic [lzpd_pkg::LEN_W-1:0]    len_left;
  logic [lzpd_pkg::DIST_W-1:0]   match_dist;
  logic                          held_last;
  logic                          err_q;

  logic [lzpd_pkg::CNT_W-1:0]    lim;
  logic [lzpd_pkg::CNT_W-1:0]    count_inc;
  logic [lzpd_pkg::BYTE_W-1:0]   lit_n;
  logic                          lit_over;
  logic [lzpd_pkg::LEN_W-1:0]    m_len;
  logic [lzpd_pkg::DIST_W-1:0]   m_dist;
  logic                          m_bad;
  logic                          err_comb;
  logic                          slot_free;

  logic                          ram_we;
  logic [lzpd_pkg::BYTE_W-1:0]   ram_wdata;
  logic [lzpd_pkg::BYTE_W-1:0]   ram_rdata;
  logic [AW-1:0]                 ram_raddr;

  assign lim = (out_limit < lzpd_pkg::CNT_W'(PAGE_CAP)) ?
               out_limit : lzpd_pkg::CNT_W'(PAGE_CAP);
  assign count_inc = count + 1'b1;

  assign lit_n    = {1'b0, in_byte[lzpd_pkg::LIT_W-1:0]} + 1'b1;
  assign lit_over = ({1'b0, count} + (lzpd_pkg::CNT_W+1)'(lit_n)) > {1'b0, lim};

  assign m_len  = lzpd_pkg::LEN_W'(held[6:3]) + lzpd_pkg::LEN_W'(lzpd_pkg::LEN_BIAS);
  assign m_dist = lzpd_pkg::DIST_W'({held[2:0], in_byte}) + 1'b1;
  assign m_bad  = (lzpd_pkg::CNT_W'(m_dist) > count) ||
                  (({1'b0, count} + (lzpd_pkg::CNT_W+1)'(m_len)) > {1'b0, lim});

  always_comb begin
    case (mode)
      MODE_TOKEN: begin
        if (!in_byte[lzpd_pkg::MATCH_BIT]) begin
          mode_next = lit_over ? MODE_ERR : MODE_LIT;
        end else begin
          mode_next = MODE_DIST;
        end
      end
      MODE_LIT:  mode_next = (lits == '0) ? MODE_TOKEN : MODE_LIT;
      MODE_DIST: mode_next = m_bad ? MODE_ERR : MODE_TOKEN;
      default:   mode_next = MODE_ERR;
    endcase
  end

  assign err_comb  = (mode_next != MODE_TOKEN);
  assign slot_free = !out_valid || out_ready;

  assign stat.slot_free = slot_free;
  assign stat.is_lit    = (mode == MODE_LIT);
  assign stat.is_match  = (mode == MODE_DIST) && !m_bad;
  assign stat.in_last   = last_in;
  assign stat.match_end = (len_left == lzpd_pkg::LEN_W'(1));
  assign stat.held_last = held_last;

  // parse state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_TOKEN;
      lits      <= '0;
      held      <= '0;
      held_last <= 1'b0;
      err_q     <= 1'b0;
    end else if (cmd.accept) begin
      mode <= last_in ? MODE_TOKEN : mode_next;
      if (mode == MODE_TOKEN && !in_byte[lzpd_pkg::MATCH_BIT]) begin
        lits <= in_byte[lzpd_pkg::LIT_W-1:0];
      end else if (mode == MODE_LIT && lits != '0) begin
        lits <= lits - 1'b1;
      end
      if (mode == MODE_TOKEN && in_byte[lzpd_pkg::MATCH_BIT]) begin
        held <= in_byte;
      end
      if (last_in) begin
        lits <= '0;
        held <= '0;
      end
      if (cmd.match_start) begin
        held_last <= last_in;
      end
      err_q <= last_in && err_comb;
    end
  end

  // match length and distance, payload only
  always_ff @(posedge clk) begin
    if (cmd.match_start) begin
      len_left   <= m_len;
      match_dist <= m_dist;
    end else if (cmd.mwr) begin
      len_left <= len_left - 1'b1;
    end
  end

  // byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.lit_emit || cmd.mwr) begin
      count <= count_inc;
    end else if (cmd.status_now || cmd.status) begin
      count <= '0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.lit_emit || cmd.mwr || cmd.status_now || cmd.status) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.lit_emit) begin
      out_item <= '{out_byte: in_byte, byte_valid: 1'b1, run_last: !last_in,
                    done_res: 1'b0, error: 1'b0, out_count: count_inc};
    end else if (cmd.mwr) begin
      out_item <= '{out_byte: ram_rdata, byte_valid: 1'b1,
                    run_last: stat.match_end && !held_last,
                    done_res: 1'b0, error: 1'b0, out_count: count_inc};
    end else if (cmd.status_now || cmd.status) begin
      out_item <= '{out_byte: '0, byte_valid: 1'b0, run_last: 1'b1, done_res: 1'b1,
                    error: cmd.status_now ? err_comb : err_q, out_count: count};
    end
  end

  assign ram_we    = cmd.lit_emit || cmd.mwr;
  assign ram_wdata = cmd.lit_emit ? in_byte : ram_rdata;
  assign ram_raddr = AW'(count - lzpd_pkg::CNT_W'(match_dist));

  lzpd_ram #(
    .WIDTH (lzpd_pkg::BYTE_W),
    .DEPTH (PAGE_SIZE)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(count)),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

`default_nettype wire

### hdl/lzpd_ctrl.sv
// Controller: sequences input beats, match copies and the final status.
`default_nettype none

module lzpd_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output      logic               in_ready,
  input  wire lzpd_pkg::dp_stat_t stat,
  output      lzpd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MRD,
    S_MWR,
    S_STAT
  } state_t;

  state_t state, state_next;
  logic   accept;

  assign in_ready = (state == S_IDLE) && stat.slot_free;
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          if (stat.is_lit) begin
            cmd.lit_emit = 1'b1;
            if (stat.in_last) begin
              state_next = S_STAT;
            end
          end else if (stat.is_match) begin
            cmd.match_start = 1'b1;
            state_next      = S_MRD;
          end else if (stat.in_last) begin
            cmd.status_now = 1'b1;
          end
        end
      end
      S_MRD: begin
        cmd.rd     = 1'b1;
        state_next = S_MWR;
      end
      S_MWR: begin
        if (stat.slot_free) begin
          cmd.mwr = 1'b1;
          if (!stat.match_end) begin
            state_next = S_MRD;
          end else if (stat.held_last) begin
            state_next = S_STAT;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_STAT: begin
        if (stat.slot_free) begin
          cmd.status = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

### hdl/lz_page_decompressor.sv
// Top level of the LZ page decompressor: config register, controller and datapath.
`default_nettype none

// Restores a page from a byte-token LZ stream, one compressed beat in at a time.
// Token and distance beats, and literal beats, are taken while the output register
// is free; a literal beat yields its byte on the next cycle. Each match byte is
// read in S_MRD and written in S_MWR, since the history is one RAM with one write
// and one registered read port and an overlapping copy must read back the byte
// written just before it. The beat that ends the stream brings one status result
// after its bytes, sent from S_STAT when that beat is a literal or ends a match.
// out_limit is taken as min(out_limit, PAGE_SIZE) and must be written only while
// the block is idle. The history needs no clearing after reset.
module lz_page_decompressor #(
  parameter int PAGE_SIZE = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,
  lzpd_in_if.sink          in_ch,
  lzpd_out_if.source       out_ch
);

  logic [lzpd_pkg::CNT_W-1:0] out_limit;
  lzpd_pkg::dp_cmd_t          cmd;
  lzpd_pkg::dp_stat_t         stat;
  lzpd_pkg::out_item_t        out_item;
  logic                       out_valid;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= lzpd_pkg::OUT_LIMIT_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[2] == lzpd_pkg::REG_OUT_LIMIT) begin
      out_limit <= pwdata[lzpd_pkg::CNT_W-1:0];
    end
  end

  assign prdata = (paddr[2] == lzpd_pkg::REG_OUT_LIMIT) ?
                  {{(32-lzpd_pkg::CNT_W){1'b0}}, out_limit} : '0;

  lzpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lzpd_dp #(
    .PAGE_SIZE (PAGE_SIZE)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .out_limit (out_limit),
    .in_byte   (in_ch.in_byte),
    .last_in   (in_ch.last_in),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign out_ch.valid      = out_valid;
  assign out_ch.out_byte   = out_item.out_byte;
  assign out_ch.byte_valid = out_item.byte_valid;
  assign out_ch.run_last   = out_item.run_last;
  assign out_ch.done_res   = out_item.done_res;
  assign out_ch.error      = out_item.error;
  assign out_ch.out_count  = out_item.out_count;

endmodule

`default_nettype wire

### hdl/lzpd_checker.sv
// Port-level checks for the LZ page decompressor, bound to the top level.
`default_nettype none

module lzpd_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [lzpd_pkg::BYTE_W-1:0] out_byte,
  input wire logic                        byte_valid,
  input wire logic                        run_last,
  input wire logic                        done_res,
  input wire logic                        error,
  input wire logic [lzpd_pkg::CNT_W-1:0]  out_count
);

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(out_count) &&
                                $stable(done_res) && $stable(error))
    else $error("output beat changed while stalled");

  // status closes its input and carries no byte
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> run_last && !byte_valid)
    else $error("status beat malformed");

  a_byte_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && byte_valid |-> !error && !done_res)
    else $error("byte beat flagged as status or error");

  // no input taken while a result is stuck
  a_stall_blocks_in: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while output stalled");

endmodule

bind lz_page_decompressor lzpd_checker u_lzpd_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .run_last   (out_ch.run_last),
  .done_res   (out_ch.done_res),
  .error      (out_ch.error),
  .out_count  (out_ch.out_count)
);

`default_nettype wire
